// ===== rtl/core/owdm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// owdm_pkg
// shared types and constants for the dual-line 1-wire master
// ----------------------------------------------------------------------------
package owdm_pkg;

  // tick counter width
  localparam int CNT_W = 10;
  // width of each timing register
  localparam int REG_W = 10;
  localparam int NUM_REGS = 7;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] CMAX = '1;

  typedef logic [1:0] cmd_t;

  // command codes carried by a tick beat
  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_RESET = 2'd1;
  localparam cmd_t CMD_WRITE = 2'd2;
  localparam cmd_t CMD_READ  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_RESET_LOW   = 3'd0;
  localparam logic [2:0] REG_RESET_REL   = 3'd1;
  localparam logic [2:0] REG_PRES_TMO    = 3'd2;
  localparam logic [2:0] REG_SLOT_BUS0   = 3'd3;
  localparam logic [2:0] REG_SLOT_BUS1   = 3'd4;
  localparam logic [2:0] REG_SHORT_PULSE = 3'd5;
  localparam logic [2:0] REG_SAMPLE_DLY  = 3'd6;

  localparam logic [REG_W-1:0] RST_RESET_LOW   = 10'd750;
  localparam logic [REG_W-1:0] RST_RESET_REL   = 10'd15;
  localparam logic [REG_W-1:0] RST_PRES_TMO    = 10'd240;
  localparam logic [REG_W-1:0] RST_SLOT_BUS0   = 10'd60;
  localparam logic [REG_W-1:0] RST_SLOT_BUS1   = 10'd65;
  localparam logic [REG_W-1:0] RST_SHORT_PULSE = 10'd2;
  localparam logic [REG_W-1:0] RST_SAMPLE_DLY  = 10'd12;

  typedef struct packed {
    logic [REG_W-1:0] reset_low;
    logic [REG_W-1:0] reset_rel;
    logic [REG_W-1:0] pres_tmo;
    logic [REG_W-1:0] slot_bus0;
    logic [REG_W-1:0] slot_bus1;
    logic [REG_W-1:0] short_pulse;
    logic [REG_W-1:0] sample_dly;
  } cfg_t;

  typedef struct packed {
    logic       drive_level_0;
    logic       drive_level_1;
    logic       busy_res;
    logic       done_res;
    logic       presence_error;
    logic [7:0] received_byte;
  } res_t;

  // clamp a programmed duration to what the tick counter can reach
  function automatic logic [CNT_W-1:0] clamp_len(input logic [REG_W-1:0] len);
    logic [REG_W+CNT_W-1:0] l_ext;
    logic [REG_W+CNT_W-1:0] m_ext;
    l_ext = (REG_W+CNT_W)'(len);
    m_ext = (REG_W+CNT_W)'(CMAX);
    if (l_ext > m_ext) begin
      return CMAX;
    end
    return CNT_W'(len);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/owdm_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// owdm_cfg
// apb register file holding the bus timing registers
// ----------------------------------------------------------------------------
module owdm_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [owdm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [owdm_pkg::DATA_W-1:0]  pwdata,
  output logic      [owdm_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output owdm_pkg::cfg_t                    cfg
);

  logic [2:0]                     idx;
  logic                           wr;
  logic [owdm_pkg::REG_W-1:0]     wval;
  logic [owdm_pkg::REG_W-1:0]     rval;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign wval   = pwdata[owdm_pkg::REG_W-1:0];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low   <= owdm_pkg::RST_RESET_LOW;
      cfg.reset_rel   <= owdm_pkg::RST_RESET_REL;
      cfg.pres_tmo    <= owdm_pkg::RST_PRES_TMO;
      cfg.slot_bus0   <= owdm_pkg::RST_SLOT_BUS0;
      cfg.slot_bus1   <= owdm_pkg::RST_SLOT_BUS1;
      cfg.short_pulse <= owdm_pkg::RST_SHORT_PULSE;
      cfg.sample_dly  <= owdm_pkg::RST_SAMPLE_DLY;
    end else if (wr) begin
      unique case (idx)
        owdm_pkg::REG_RESET_LOW:   cfg.reset_low   <= wval;
        owdm_pkg::REG_RESET_REL:   cfg.reset_rel   <= wval;
        owdm_pkg::REG_PRES_TMO:    cfg.pres_tmo    <= wval;
        owdm_pkg::REG_SLOT_BUS0:   cfg.slot_bus0   <= wval;
        owdm_pkg::REG_SLOT_BUS1:   cfg.slot_bus1   <= wval;
        owdm_pkg::REG_SHORT_PULSE: cfg.short_pulse <= wval;
        owdm_pkg::REG_SAMPLE_DLY:  cfg.sample_dly  <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      owdm_pkg::REG_RESET_LOW:   rval = cfg.reset_low;
      owdm_pkg::REG_RESET_REL:   rval = cfg.reset_rel;
      owdm_pkg::REG_PRES_TMO:    rval = cfg.pres_tmo;
      owdm_pkg::REG_SLOT_BUS0:   rval = cfg.slot_bus0;
      owdm_pkg::REG_SLOT_BUS1:   rval = cfg.slot_bus1;
      owdm_pkg::REG_SHORT_PULSE: rval = cfg.short_pulse;
      owdm_pkg::REG_SAMPLE_DLY:  rval = cfg.sample_dly;
      default:                   rval = '0;
    endcase
  end

  assign prdata = owdm_pkg::DATA_W'(rval);

endmodule
`default_nettype wire

// ===== rtl/core/owdm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// owdm_ctrl
// per-tick bus sequencer: reset/presence, byte write and byte read slots
// ----------------------------------------------------------------------------
module owdm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [1:0]     cmd,
  input  wire logic           bus_select,
  input  wire logic [7:0]     byte_to_send,
  input  wire logic           line_sense_0,
  input  wire logic           line_sense_1,
  input  owdm_pkg::cfg_t      cfg,
  output owdm_pkg::res_t      res
);

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_RST_LOW   = 4'd1;
  localparam logic [3:0] PH_RST_REL   = 4'd2;
  localparam logic [3:0] PH_PRES_FALL = 4'd3;
  localparam logic [3:0] PH_PRES_RISE = 4'd4;
  localparam logic [3:0] PH_W_LOW     = 4'd5;
  localparam logic [3:0] PH_W_HIGH    = 4'd6;
  localparam logic [3:0] PH_R_LOW     = 4'd7;
  localparam logic [3:0] PH_R_WAIT    = 4'd8;
  localparam logic [3:0] PH_R_REST    = 4'd9;

  logic [3:0]                  phase, phase_next;
  logic [owdm_pkg::CNT_W-1:0]  tick_count, tick_count_next;
  logic [2:0]                  bit_index, bit_index_next;
  logic [7:0]                  shift_byte, shift_byte_next;
  logic                        active_bus, active_bus_next;
  logic                        error_flag, error_flag_next;
  logic [7:0]                  rx_byte, rx_byte_next;

  logic                        sense;
  logic                        cur_bit;
  logic [owdm_pkg::REG_W-1:0]  slot_len;
  logic [owdm_pkg::REG_W-1:0]  len_sel;
  logic [owdm_pkg::CNT_W-1:0]  lim;
  logic [owdm_pkg::CNT_W-1:0]  tc_inc;
  logic                        fin;
  logic                        low;
  logic                        done;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    active_bus_next = active_bus;
    error_flag_next = error_flag;
    rx_byte_next    = rx_byte;
    low             = 1'b0;
    done            = 1'b0;

    // command start: the start beat is already the first tick of the op
    if (phase == PH_IDLE && cmd != owdm_pkg::CMD_TICK) begin
      active_bus_next = bus_select;
      bit_index_next  = '0;
      tick_count_next = '0;
      if (cmd == owdm_pkg::CMD_RESET) begin
        phase_next = PH_RST_LOW;
      end else if (cmd == owdm_pkg::CMD_WRITE) begin
        shift_byte_next = byte_to_send;
        phase_next      = PH_W_LOW;
      end else begin
        shift_byte_next = '0;
        phase_next      = PH_R_LOW;
      end
    end

    sense    = active_bus_next ? line_sense_1 : line_sense_0;
    cur_bit  = shift_byte_next[0];
    slot_len = active_bus_next ? cfg.slot_bus1 : cfg.slot_bus0;

    unique case (phase_next)
      PH_RST_LOW:   len_sel = cfg.reset_low;
      PH_RST_REL:   len_sel = cfg.reset_rel;
      PH_PRES_FALL: len_sel = cfg.pres_tmo;
      PH_PRES_RISE: len_sel = cfg.pres_tmo;
      PH_W_LOW:     len_sel = cur_bit ? cfg.short_pulse : slot_len;
      PH_W_HIGH:    len_sel = cur_bit ? slot_len : cfg.short_pulse;
      PH_R_LOW:     len_sel = cfg.short_pulse;
      PH_R_WAIT:    len_sel = cfg.sample_dly;
      PH_R_REST:    len_sel = slot_len;
      default:      len_sel = '0;
    endcase

    lim    = owdm_pkg::clamp_len(len_sel);
    // saturating tick counter
    tc_inc = (tick_count_next < owdm_pkg::CMAX) ? tick_count_next + 1'b1 : tick_count_next;
    fin    = tc_inc >= lim;

    unique case (phase_next)
      PH_RST_LOW: begin
        low             = 1'b1;
        tick_count_next = tc_inc;
        if (fin) begin
          phase_next      = PH_RST_REL;
          tick_count_next = '0;
        end
      end
      PH_RST_REL: begin
        tick_count_next = tc_inc;
        if (fin) begin
          phase_next      = PH_PRES_FALL;
          tick_count_next = '0;
        end
      end
      PH_PRES_FALL: begin
        if (!sense) begin
          phase_next      = PH_PRES_RISE;
          tick_count_next = '0;
        end else if (fin) begin
          error_flag_next = 1'b1;
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          done            = 1'b1;
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_PRES_RISE: begin
        if (sense) begin
          error_flag_next = 1'b0;
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          done            = 1'b1;
        end else if (fin) begin
          error_flag_next = 1'b1;
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          done            = 1'b1;
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_W_LOW: begin
        low             = 1'b1;
        tick_count_next = tc_inc;
        if (fin) begin
          phase_next      = PH_W_HIGH;
          tick_count_next = '0;
        end
      end
      PH_W_HIGH: begin
        tick_count_next = tc_inc;
        if (fin) begin
          shift_byte_next = {1'b0, shift_byte_next[7:1]};
          tick_count_next = '0;
          if (bit_index_next == 3'd7) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next     = PH_W_LOW;
          end
        end
      end
      PH_R_LOW: begin
        low             = 1'b1;
        tick_count_next = tc_inc;
        if (fin) begin
          phase_next      = PH_R_WAIT;
          tick_count_next = '0;
        end
      end
      PH_R_WAIT: begin
        tick_count_next = tc_inc;
        if (fin) begin
          // sample lands in the msb, byte arrives lsb first
          shift_byte_next = {sense, shift_byte_next[7:1]};
          phase_next      = PH_R_REST;
          tick_count_next = '0;
        end
      end
      PH_R_REST: begin
        tick_count_next = tc_inc;
        if (fin) begin
          tick_count_next = '0;
          if (bit_index_next == 3'd7) begin
            rx_byte_next = shift_byte_next;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next     = PH_R_LOW;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    res.drive_level_0  = !(low && !active_bus_next);
    res.drive_level_1  = !(low && active_bus_next);
    res.busy_res       = phase_next != PH_IDLE;
    res.done_res       = done;
    res.presence_error = error_flag_next;
    res.received_byte  = rx_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      active_bus <= 1'b0;
      error_flag <= 1'b0;
      rx_byte    <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      active_bus <= active_bus_next;
      error_flag <= error_flag_next;
      rx_byte    <= rx_byte_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/owdm_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// owdm_out_buf
// result register with one skid entry so the input side keeps flowing
// ----------------------------------------------------------------------------
module owdm_out_buf (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  owdm_pkg::res_t   push_data,
  output logic             full,
  output logic             valid,
  input  wire logic        stall,
  output owdm_pkg::res_t   data
);

  logic            main_valid;
  logic            skid_valid;
  owdm_pkg::res_t  skid_data;
  logic            pop;

  assign pop   = main_valid && !stall;
  assign valid = main_valid;
  assign full  = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // payload path, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        data <= skid_data;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        data <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/one_wire_dual_bus_master_top.sv =====
`default_nettype none
// an accepted tick beat's result is registered into the result register, or into its skid entry
// throughput: one beat per cycle while in_stall is low, the whole tick update sits between the
//   sequencer state registers and the result register
// in_stall rises only when the result register and its skid entry are both full
// reset (rst, synchronous): sequencer idle, counters and received byte cleared,
//   timing registers back to defaults, no result pending
// ----------------------------------------------------------------------------
// one_wire_dual_bus_master_top
// two-line 1-wire master stepped by one-microsecond tick beats
// ----------------------------------------------------------------------------
module one_wire_dual_bus_master_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [owdm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [owdm_pkg::DATA_W-1:0]  pwdata,
  output logic      [owdm_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   cmd,
  input  wire logic                         bus_select,
  input  wire logic [7:0]                   byte_to_send,
  input  wire logic                         line_sense_0,
  input  wire logic                         line_sense_1,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              drive_level_0,
  output logic                              drive_level_1,
  output logic                              busy_res,
  output logic                              done_res,
  output logic                              presence_error,
  output logic [7:0]                        received_byte
);

  owdm_pkg::cfg_t cfg;
  owdm_pkg::res_t res;
  owdm_pkg::res_t out_data;
  logic           accept;
  logic           buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  owdm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owdm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (cmd),
    .bus_select   (bus_select),
    .byte_to_send (byte_to_send),
    .line_sense_0 (line_sense_0),
    .line_sense_1 (line_sense_1),
    .cfg          (cfg),
    .res          (res)
  );

  owdm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (buf_full),
    .valid     (out_valid),
    .stall     (out_stall),
    .data      (out_data)
  );

  assign drive_level_0  = out_data.drive_level_0;
  assign drive_level_1  = out_data.drive_level_1;
  assign busy_res       = out_data.busy_res;
  assign done_res       = out_data.done_res;
  assign presence_error = out_data.presence_error;
  assign received_byte  = out_data.received_byte;

endmodule
`default_nettype wire
